// ===== rtl/randomized_set_table_core_defines.svh =====
// Assertion macros for the randomized set table core.
// Included by the top level; no other dependencies.
`ifndef RANDOMIZED_SET_TABLE_CORE_DEFINES_SVH
`define RANDOMIZED_SET_TABLE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RST_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RST_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RST_ASSERT(label, clk, rst, prop, msg)
`define RST_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/rst_pkg.sv =====
// Package for the randomized set table: codes, widths, command type.
// No dependencies.
`timescale 1ns / 1ps
package rst_pkg;
  localparam int DefCapacity = 64;
  localparam int ValueW = 32;
  localparam int DrawW = 31;
  localparam int CountW = 7;

  typedef enum logic [1:0] {OP_INSERT = 2'd0, OP_REMOVE = 2'd1, OP_DRAW = 2'd2,
                            OP_NONE = 2'd3} op_t;
  typedef enum logic [1:0] {ST_DONE = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2,
                            ST_EMPTY = 2'd3} status_t;

  typedef struct packed {
    op_t                op;
    logic [ValueW-1:0]  value;
    logic [DrawW-1:0]   random_draw;
  } cmd_t;

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_MOD, S_READ, S_LAST, S_MOVE,
                            S_OUT} eng_state_t;
endpackage

// ===== rtl/randomized_set_table_core.sv =====
// Randomized set table: sequential engine, one item at a time in the back end.
// Insert and remove search the store; a draw is reduced by a 31-step restoring
// modulo by count; a draw on an empty set or the unused code goes straight to
// the result. The back end takes no new item until its result has been taken;
// a two-item queue buffers input.
// Synchronous active-high reset empties the set; no clearing pass needed.
`timescale 1ns / 1ps
module randomized_set_table_core #(
  parameter int Capacity = rst_pkg::DefCapacity
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // operation[1:0], value[33:2], random_draw[64:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status[1:0], element[33:2], count[40:34]
);
  import rst_pkg::*;
  `include "randomized_set_table_core_defines.svh"

  cmd_t in_cmd, cmd;
  logic cmd_valid, cmd_ready;
  logic [1:0] st;
  logic [ValueW-1:0] el;
  logic [CountW-1:0] ct;

  assign in_cmd.op          = op_t'(s_tdata[1:0]);
  assign in_cmd.value       = s_tdata[33:2];
  assign in_cmd.random_draw = s_tdata[64:34];

  // Front: accept and queue.
  rst_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd,
    .cmd_valid, .cmd_ready, .cmd
  );

  // Back: execute against the store.
  rst_back #(.Capacity(Capacity)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(m_tvalid), .res_ready(m_tready),
    .res_status(st), .res_element(el), .res_count(ct)
  );

  assign m_tdata = {7'd0, ct, el, st};

  `RST_ASSERT(a_count_bound, clk, rst, (ct <= CountW'(Capacity)), "count over capacity")
  `RST_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
endmodule

// ===== rtl/rst_front.sv =====
// Front end: accepts items and queues them as commands (two-entry queue).
// Depends on rst_pkg.
`timescale 1ns / 1ps
module rst_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rst_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output rst_pkg::cmd_t cmd
);
  import rst_pkg::*;
  cmd_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_cmd;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/rst_back.sv =====
// Back end: searches the store, reduces draws modulo count, updates store.
// Depends on rst_pkg.
`timescale 1ns / 1ps
module rst_back #(
  parameter int Capacity = rst_pkg::DefCapacity
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  rst_pkg::cmd_t              cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [1:0]                 res_status,
  output logic [rst_pkg::ValueW-1:0] res_element,
  output logic [rst_pkg::CountW-1:0] res_count
);
  import rst_pkg::*;
  localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW = $clog2(Capacity + 1);
  localparam int ModW = DrawW + CntW;

  logic [ValueW-1:0] store [Capacity];
  eng_state_t state, state_next;
  cmd_t       cur;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] idx;
  logic [AW-1:0]   hit_slot;
  logic [ValueW-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [ModW-1:0]   rem;
  logic [5:0]        mbit;
  logic              hit;
  logic              match;
  logic              st_we;
  logic [AW-1:0]     st_wa;
  logic [ValueW-1:0] st_wd;

  logic [ModW-1:0] divs;
  assign divs = ModW'(cnt) << mbit;

  // rd_data is a registered read of store[idx], so it holds store[idx-1] as idx advances
  assign match = (idx != '0) && (rd_data == cur.value);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd_valid) begin
        if (cmd.op == OP_DRAW) state_next = (cnt == '0) ? S_OUT : S_MOD;
        else if (cmd.op == OP_NONE) state_next = S_OUT;
        else state_next = S_SEARCH;
      end
      S_SEARCH: if (match) state_next = (cur.op == OP_REMOVE) ? S_LAST : S_MOVE;
                else if (idx == cnt) state_next = S_MOVE;
      S_MOD:    if (mbit == 6'd0) state_next = S_READ;
      S_READ:   state_next = S_OUT;
      S_LAST:   state_next = S_MOVE;
      S_MOVE:   state_next = S_OUT;
      S_OUT:    if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == S_IDLE);
    res_valid = (state == S_OUT);
    // Hold the reduced draw index on the read port through the result.
    rd_addr = idx[AW-1:0];
    if (state == S_READ || state == S_OUT) rd_addr = AW'(rem);
    st_we = 1'b0;
    st_wa = cnt[AW-1:0];
    st_wd = cur.value;
    if (state == S_MOVE) begin
      if (cur.op == OP_INSERT) begin
        st_we = !hit && (cnt != CntW'(Capacity));
      end else begin
        st_we = hit;
        st_wa = hit_slot;
        st_wd = rd_data;
      end
    end
    res_element = (cur.op == OP_DRAW && res_status == ST_DONE) ? rd_data : '0;
  end

  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= st_wd;
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (cmd_valid) begin
          cur <= cmd;
          idx <= '0;
          hit <= 1'b0;
          res_status <= (cmd.op == OP_DRAW && cnt == '0) ? ST_EMPTY : ST_DONE;
          rem  <= ModW'(cmd.random_draw);
          mbit <= 6'(DrawW - 1);
        end
        S_SEARCH: begin
          if (match) begin
            hit <= 1'b1;
            hit_slot <= AW'(idx - 1'b1);
            // point the read port at the last entry for a remove
            idx <= cnt - 1'b1;
          end else if (idx != cnt) begin
            idx <= idx + 1'b1;
          end
        end
        S_MOD: begin
          if (rem >= divs) rem <= rem - divs;
          mbit <= mbit - 6'd1;
        end
        S_MOVE: begin
          if (cur.op == OP_INSERT) begin
            if (hit) res_status <= ST_MISS;
            else if (cnt == CntW'(Capacity)) res_status <= ST_FULL;
            else cnt <= cnt + 1'b1;
          end else begin
            if (!hit) res_status <= ST_MISS;
            else cnt <= cnt - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_count = CountW'(cnt);
endmodule

// ===== tb/sv/randomized_set_table_core_tb.sv =====
// Testbench for randomized_set_table_core: directed and random set operations,
// checked item by item against a behavioral model of the set kept here.
// Depends on rst_pkg and the core RTL.
`timescale 1ns / 1ps
module randomized_set_table_core_tb;
  import rst_pkg::*;

  localparam int Cap = DefCapacity;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // operation[1:0], value[33:2], random_draw[64:34]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // status[1:0], element[33:2], count[40:34]

  randomized_set_table_core #(.Capacity(Cap)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  typedef struct {
    status_t     status;
    logic [31:0] element;
    logic [6:0]  count;
  } set_result_t;

  // Model copy of the set contents
  logic [31:0] set_store [Cap];
  int          set_size;
  set_result_t pending_results [$];
  int          error_count;
  bit          hold_results;   // long receiver stall while set
  bit          rx_random;      // receiver draws random gaps
  int          rx_wait = 0;    // cycles left before the receiver takes the next item

  // Apply one operation to the model and return the expected result.
  function automatic set_result_t apply_op(op_t op, logic [31:0] key, logic [30:0] draw);
    set_result_t r;
    int slot;
    slot = -1;
    r.status = ST_DONE;
    r.element = '0;
    for (int i = 0; i < set_size; i++)
      if (slot < 0 && set_store[i] == key) slot = i;
    case (op)
      OP_INSERT: begin
        if (slot >= 0) r.status = ST_MISS;
        else if (set_size >= Cap) r.status = ST_FULL;
        else begin
          set_store[set_size] = key;
          set_size++;
        end
      end
      OP_REMOVE: begin
        if (slot < 0) r.status = ST_MISS;
        else begin
          set_store[slot] = set_store[set_size - 1];
          set_size--;
        end
      end
      OP_DRAW: begin
        if (set_size == 0) r.status = ST_EMPTY;
        else r.element = set_store[draw % set_size];
      end
      default: ;
    endcase
    r.count = set_size[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Offer one item, hold it until accepted, then optionally idle.
  task automatic send_op(input op_t op, input logic [31:0] key, input logic [30:0] draw,
                         input bit gaps = 1'b1);
    int gap;
    pending_results.push_back(apply_op(op, key, draw));
    s_tdata <= {7'd0, draw, key, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drop_valid();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
      end else begin
        set_result_t w;
        w = pending_results.pop_front();
        if (m_tdata[1:0] != w.status)
          report_mismatch("status", 32'(m_tdata[1:0]), 32'(w.status));
        if (m_tdata[33:2] != w.element) report_mismatch("element", m_tdata[33:2], w.element);
        if (m_tdata[40:34] != w.count)
          report_mismatch("count", 32'(m_tdata[40:34]), 32'(w.count));
      end
    end
  end

  // Receiver readiness: draw a random wait per item, or steady, or held off.
  always @(posedge clk) begin
    if (hold_results) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      rx_wait = rx_random ? $urandom_range(0, 3) : 0;
      m_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= (rx_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // Pick a value currently in the set, or a random one if it is empty.
  function automatic logic [31:0] member_or_random();
    if (set_size == 0) return rand_word();
    return set_store[$urandom_range(0, set_size - 1)];
  endfunction

  // Extremes, every operation and the miss and empty cases.
  task automatic test_directed();
    send_op(OP_DRAW, 32'd0, 31'h7fffffff);        // draw on empty set
    send_op(OP_REMOVE, 32'h8000_0000, 31'd0);     // remove from empty set
    send_op(OP_NONE, 32'hffff_ffff, 31'h7fffffff); // unused code is a no-op
    send_op(OP_INSERT, 32'h8000_0000, 31'd0);
    send_op(OP_INSERT, 32'h7fff_ffff, 31'd0);
    send_op(OP_INSERT, 32'hffff_ffff, 31'd0);
    send_op(OP_INSERT, 32'd0, 31'd0);
    send_op(OP_INSERT, 32'h7fff_ffff, 31'd0);     // already present
    send_op(OP_DRAW, 32'hffff_ffff, 31'd0);
    send_op(OP_DRAW, 32'd0, 31'h7fffffff);
    send_op(OP_DRAW, 32'd0, 31'h5555_5555);
    send_op(OP_DRAW, 32'd0, 31'h2aaa_aaaa);
    send_op(OP_REMOVE, 32'd0, 31'd0);             // remove the last entry
    send_op(OP_REMOVE, 32'h8000_0000, 31'd0);     // remove first, last moves in
    send_op(OP_REMOVE, 32'h1234_5678, 31'd0);     // absent
    send_op(OP_NONE, 32'h0, 31'h0);
    drop_valid();
  endtask

  // Fill to capacity, then hit full and present-in-full, then drain.
  task automatic test_full_store();
    logic [31:0] v;
    while (set_size < Cap) begin
      v = rand_word();
      send_op(OP_INSERT, v, 31'd0);
    end
    send_op(OP_INSERT, ~set_store[0] ^ 32'h1, 31'd0);
    send_op(OP_INSERT, 32'h5a5a_0000, 31'd0);
    send_op(OP_INSERT, set_store[Cap - 1], 31'd0);
    send_op(OP_DRAW, 32'd0, 31'h7fffffff);
    send_op(OP_DRAW, 32'd0, 31'd63);
    while (set_size > 0) send_op(OP_REMOVE, member_or_random(), 31'd0);
    drop_valid();
  endtask

  // Hold the receiver off while items keep coming, so the core stalls.
  task automatic test_backpressure();
    hold_results = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_results = 1'b0;
      end
      repeat (12) send_op(OP_INSERT, rand_word(), 31'($urandom()), 1'b0);
    join
    drop_valid();
  endtask

  // Mostly meaningful traffic: members removed and drawn, fresh values inserted.
  task automatic test_random_mix(input int n);
    int pick;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      rx_random = (i % 200) < 150;
      if (pick < 35) begin
        v = ($urandom_range(0, 3) == 0) ? member_or_random() : rand_word();
        send_op(OP_INSERT, v, 31'($urandom()));
      end else if (pick < 60) begin
        v = ($urandom_range(0, 4) == 0) ? rand_word() : member_or_random();
        send_op(OP_REMOVE, v, 31'($urandom()));
      end else if (pick < 97) begin
        send_op(OP_DRAW, rand_word(), 31'($urandom()));
      end else begin
        send_op(OP_NONE, rand_word(), 31'($urandom()));
      end
    end
    drop_valid();
  endtask

  initial begin
    int guard;
    error_count = 0;
    set_size = 0;
    hold_results = 1'b0;
    rx_random = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_backpressure();
    test_random_mix(760);
    rx_random = 1'b1;
    guard = 0;
    while (pending_results.size() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: ~1000 items at the slowest time per item, taken several times over.
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
